// ----- hw/rtl/tdc_pkg.sv -----
package tdc_pkg;

   // Field widths of the stream and register ports.
   localparam int unsigned REQ_TDATA_W = 56;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 22;

   localparam int unsigned MAX_PAYLOAD_DEF = 64;

   // Operation codes carried in req_tuser.
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_HEADER  = 2'd1;
   localparam logic [1:0] OP_PUBLISH = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Result kinds carried in rsp_tuser.
   localparam logic KIND_TRANSMIT = 1'b0;
   localparam logic KIND_DELIVER  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUP_THRESHOLD = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic start_iv;
      logic commit_listen;
      logic start_first;
      logic commit_first;
   } tdc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_interval;
      logic need_first;
      logic mod_done;
   } tdc_status_type;

   // Results produced by one transaction; a second result is always a transmit.
   typedef struct packed {
      logic [1:0] count;
      logic       kind0;
      logic [7:0] seqno;
      logic [6:0] length;
   } tdc_push_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] seqno;
      logic [6:0] length;
      logic       last;
   } tdc_entry_type;

endpackage

// ----- hw/rtl/trickle_dissemination_ctrl.sv -----
// Trickle dissemination controller.
// req_* carries one command per transaction: a timer tick, a received header or
// a local publish, chosen by req_tuser. rsp_* returns zero, one or two results
// per command, each a transmit or a deliver of the held version; rsp_tlast
// marks the final result of a command. csr_* writes the base interval, maximum
// interval and duplicate threshold; the user must write it only while the block
// is idle; the block itself does not enforce this. Commands are handled one at
// a time. A command that starts no new interval returns to idle after its execute
// step, which pushes its results into the queue in the cycle after acceptance.
// Starting an interval adds a run of the serial 16-bit modulo of the random listen
// value by half the interval; adopting a newer header runs that unit a second time
// for the first-send delay. Results wait in a four-entry queue; a new command is
// taken while at most two results are queued, so a stalled receiver holds off
// req_tready once more than two are queued. Reset returns the configuration
// registers to their defaults, clears the version and stops all timers; no
// interval runs until a header is adopted or a version is published.
module trickle_dissemination_ctrl #(
   parameter int unsigned MAX_PAYLOAD = tdc_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: seqno_in[7:0], length_in[23:8], rand_listen[39:24], rand_first[55:40]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tdc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: op[1:0]
   input  logic [tdc_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // rsp_tdata: out_seqno[7:0], out_length[14:8], zero[15]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tdc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: kind[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [tdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import tdc_pkg::*;

   tdc_cmd_type    cmd;
   tdc_status_type sts;
   tdc_push_type   push;
   logic           out_room;

   tdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_room   (out_room),
      .sts        (sts),
      .cmd        (cmd)
   );

   tdc_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   tdc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (out_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Commands are processed one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while the previous one is in progress");

   // A delivered or transmitted length never exceeds the payload limit.
   a_length_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:8] <= 7'(MAX_PAYLOAD))
      else $error("result length above the payload limit");

   // Two results only come from a tick, and both are transmits.
   a_pair_is_transmit: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.kind0 == KIND_TRANSMIT)
      else $error("result pair with a deliver");

   // Results are produced only in the execute step, never during the modulo runs.
   a_push_on_exec: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> cmd.exec)
      else $error("results pushed outside the execute step");

endmodule

// ----- hw/rtl/tdc_modulo.sv -----
module tdc_modulo (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [21:0] divisor,
   output logic        done,
   output logic [21:0] remainder
);

   localparam int unsigned DIVIDEND_W = 16;
   localparam int unsigned CNT_W      = $clog2(DIVIDEND_W);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [21:0]           rem_ff;
   logic [21:0]           rem_in;
   logic [DIVIDEND_W-1:0] shreg_ff;
   logic [21:0]           div_ff;
   logic [22:0]           trial;
   logic                  fits;

   // Restoring division, one dividend bit per cycle; only the remainder is kept.
   assign trial  = {rem_ff, shreg_ff[DIVIDEND_W-1]};
   assign fits   = trial >= {1'b0, div_ff};
   assign rem_in = fits ? 22'(trial - {1'b0, div_ff}) : trial[21:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff   <= '0;
         rem_ff   <= '0;
         shreg_ff <= dividend;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         cnt_ff   <= cnt_ff + 1'b1;
         rem_ff   <= rem_in;
         shreg_ff <= {shreg_ff[DIVIDEND_W-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   // A zero modulus gives zero.
   assign remainder = (div_ff == '0) ? '0 : rem_ff;

endmodule

// ----- hw/rtl/tdc_datapath.sv -----
module tdc_datapath #(
   parameter int unsigned MAX_PAYLOAD = tdc_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tdc_pkg::tdc_cmd_type                cmd,
   output tdc_pkg::tdc_status_type             sts,
   input  logic [tdc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [tdc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                csr_we,
   input  logic [tdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tdc_pkg::tdc_push_type               push
);

   import tdc_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LISTEN = 2'd1;
   localparam logic [1:0] PH_WAIT   = 2'd2;

   // Configuration.
   logic [15:0] base_ff;
   logic [21:0] max_ff;
   logic [7:0]  thr_ff;

   // Latched transaction.
   logic [1:0]  op_ff;
   logic [7:0]  seq_ff;
   logic [15:0] len_ff;
   logic [15:0] rl_ff;
   logic [15:0] rf_ff;

   // Protocol state.
   logic [7:0]  version_ff, version_in;
   logic [6:0]  held_ff, held_in;
   logic [4:0]  dc_ff, dc_in;
   logic [7:0]  dup_ff, dup_in;
   logic [1:0]  phase_ff, phase_in;
   logic [21:0] listen_left_ff, listen_left_in;
   logic [21:0] interval_left_ff, interval_left_in;
   logic [15:0] fs_left_ff, fs_left_in;
   logic        armed_ff, armed_in;
   logic [20:0] half_ff, half_in;

   logic [46:0] shifted_iv;
   logic        below_max;
   logic [21:0] iv_clamped;
   logic [20:0] half;
   logic        fs_fire;
   logic        lf;
   logic        ivf;
   logic        send_listen;
   logic [7:0]  diff;
   logic        len_ok;
   logic        need_interval;
   logic        need_first;
   logic [1:0]  push_count;
   logic        push_kind;

   logic        mod_start;
   logic [15:0] mod_dividend;
   logic [21:0] mod_divisor;
   logic        mod_done;
   logic [21:0] mod_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 16'd128;
         max_ff  <= 22'd4096;
         thr_ff  <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_INTERVAL: base_ff <= csr_wdata[15:0];
            CSR_MAX_INTERVAL:  max_ff  <= csr_wdata;
            CSR_DUP_THRESHOLD: thr_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_tuser;
         seq_ff <= req_tdata[7:0];
         len_ff <= req_tdata[23:8];
         rl_ff  <= req_tdata[39:24];
         rf_ff  <= req_tdata[55:40];
      end
      half_ff <= half_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff       <= '0;
         held_ff          <= '0;
         dc_ff            <= '0;
         dup_ff           <= '0;
         phase_ff         <= PH_IDLE;
         listen_left_ff   <= '0;
         interval_left_ff <= '0;
         fs_left_ff       <= '0;
         armed_ff         <= 1'b0;
      end else begin
         version_ff       <= version_in;
         held_ff          <= held_in;
         dc_ff            <= dc_in;
         dup_ff           <= dup_in;
         phase_ff         <= phase_in;
         listen_left_ff   <= listen_left_in;
         interval_left_ff <= interval_left_in;
         fs_left_ff       <= fs_left_in;
         armed_ff         <= armed_in;
      end
   end

   // Interval length for the current doubling count, before and after clamping.
   assign shifted_iv = 47'(base_ff) << dc_ff;
   assign below_max  = shifted_iv < 47'(max_ff);
   assign iv_clamped = (shifted_iv > 47'(max_ff)) ? max_ff : shifted_iv[21:0];
   assign half       = iv_clamped[21:1];

   assign fs_fire     = armed_ff && (fs_left_ff <= 16'd1);
   assign lf          = (phase_ff == PH_LISTEN) && (listen_left_ff <= 22'd1);
   assign ivf         = interval_left_ff <= 22'd1;
   assign send_listen = lf && (dup_ff < thr_ff);
   assign diff        = seq_ff - version_ff;
   assign len_ok      = len_ff <= 16'(MAX_PAYLOAD);

   always_comb begin
      version_in       = version_ff;
      held_in          = held_ff;
      dc_in            = dc_ff;
      dup_in           = dup_ff;
      phase_in         = phase_ff;
      listen_left_in   = listen_left_ff;
      interval_left_in = interval_left_ff;
      fs_left_in       = fs_left_ff;
      armed_in         = armed_ff;
      half_in          = half_ff;
      need_interval    = 1'b0;
      need_first       = 1'b0;
      push_count       = 2'd0;
      push_kind        = KIND_TRANSMIT;

      if (cmd.exec) begin
         unique case (op_ff)
            OP_TICK: begin
               // The first-send timer runs ahead of the trickle timers.
               if (armed_ff) begin
                  fs_left_in = fs_fire ? 16'd0 : fs_left_ff - 16'd1;
                  armed_in   = !fs_fire;
               end
               if (phase_ff != PH_IDLE) begin
                  if (phase_ff == PH_LISTEN) begin
                     listen_left_in = lf ? 22'd0 : listen_left_ff - 22'd1;
                  end
                  interval_left_in = ivf ? 22'd0 : interval_left_ff - 22'd1;
                  if (lf) begin
                     if (below_max && dc_ff != 5'd31) begin
                        dc_in = dc_ff + 5'd1;
                     end
                     phase_in = PH_WAIT;
                  end
                  need_interval = ivf && (phase_ff == PH_WAIT || lf);
               end
               push_count = 2'(fs_fire) + 2'(send_listen);
            end
            OP_HEADER: begin
               if (diff == 8'd0) begin
                  if (dup_ff != 8'hFF) begin
                     dup_in = dup_ff + 8'd1;
                  end
               end else if (diff[7]) begin
                  // An older version heard: answer at once.
                  dc_in      = '0;
                  push_count = 2'd1;
               end else if (len_ok) begin
                  version_in    = seq_ff;
                  held_in       = len_ff[6:0];
                  dc_in         = '0;
                  armed_in      = 1'b1;
                  need_interval = 1'b1;
                  need_first    = 1'b1;
                  push_count    = 2'd1;
                  push_kind     = KIND_DELIVER;
               end
            end
            OP_PUBLISH: begin
               held_in       = len_ok ? len_ff[6:0] : 7'(MAX_PAYLOAD);
               version_in    = version_ff + 8'd1;
               dc_in         = '0;
               need_interval = 1'b1;
               push_count    = 2'd1;
            end
            OP_NONE: ;
            default: ;
         endcase
      end

      if (cmd.start_iv) begin
         interval_left_in = iv_clamped;
         dup_in           = '0;
         phase_in         = PH_LISTEN;
         half_in          = half;
      end
      if (cmd.commit_listen) begin
         listen_left_in = 22'(half_ff) + mod_rem;
      end
      if (cmd.commit_first) begin
         fs_left_in = mod_rem[15:0];
      end
   end

   assign mod_start    = cmd.start_iv || cmd.start_first;
   assign mod_dividend = cmd.start_first ? rf_ff : rl_ff;
   assign mod_divisor  = cmd.start_first ? 22'(base_ff) : 22'(half);

   tdc_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign sts.need_interval = need_interval;
   assign sts.need_first    = need_first;
   assign sts.mod_done      = mod_done;

   // Results carry the version as it stands after this transaction.
   assign push.count  = push_count;
   assign push.kind0  = push_kind;
   assign push.seqno  = version_in;
   assign push.length = held_in;

endmodule

// ----- hw/rtl/tdc_ctrl.sv -----
module tdc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    out_room,
   input  tdc_pkg::tdc_status_type sts,
   output tdc_pkg::tdc_cmd_type    cmd
);

   import tdc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_WAIT_L = 3'd3;
   localparam logic [2:0] S_FIRST  = 3'd4;
   localparam logic [2:0] S_WAIT_F = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       need_first_ff, need_first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         need_first_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         need_first_ff <= need_first_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && out_room;

   always_comb begin
      state_in      = state_ff;
      need_first_in = need_first_ff;
      cmd           = '0;
      cmd.accept    = req_tvalid && req_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec      = 1'b1;
            need_first_in = sts.need_first;
            state_in      = sts.need_interval ? S_START : S_IDLE;
         end
         S_START: begin
            cmd.start_iv = 1'b1;
            state_in     = S_WAIT_L;
         end
         S_WAIT_L: begin
            if (sts.mod_done) begin
               cmd.commit_listen = 1'b1;
               state_in          = need_first_ff ? S_FIRST : S_IDLE;
            end
         end
         S_FIRST: begin
            cmd.start_first = 1'b1;
            state_in        = S_WAIT_F;
         end
         S_WAIT_F: begin
            if (sts.mod_done) begin
               cmd.commit_first = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/tdc_rsp_fifo.sv -----
module tdc_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  tdc_pkg::tdc_push_type            push,
   output logic                             room,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tdc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   import tdc_pkg::*;

   localparam int unsigned DEPTH   = 4;
   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned LEVEL_W = $clog2(DEPTH + 1);

   tdc_entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic                  pop;
   tdc_entry_type         rd_entry;

   assign pop      = rsp_tvalid && rsp_tready;
   // A transaction yields at most two results, so one is taken only when two slots are free.
   assign room     = level_ff <= LEVEL_W'(DEPTH - 2);
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         level_ff  <= level_ff + LEVEL_W'(push.count) - LEVEL_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= '{kind:   push.kind0,
                                seqno:  push.seqno,
                                length: push.length,
                                last:   push.count == 2'd1};
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= '{kind:   KIND_TRANSMIT,
                                            seqno:  push.seqno,
                                            length: push.length,
                                            last:   1'b1};
      end
   end

   assign rsp_tvalid = level_ff != '0;
   assign rsp_tdata  = {1'b0, rd_entry.length, rd_entry.seqno};
   assign rsp_tuser  = rd_entry.kind;
   assign rsp_tlast  = rd_entry.last;

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   import tdc_pkg::*;

   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum logic [1:0] {TRK_IDLE, TRK_LISTEN, TRK_WAIT} trickle_phase_type;

   // One directed transaction; where typed is set, the result is given here directly.
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  seqno;
      logic [15:0] length;
      logic [15:0] rnd_listen;
      logic [15:0] rnd_first;
      logic        typed;
      logic [1:0]  typed_n;
      logic        kind;
      logic [7:0]  out_seqno;
      logic [6:0]  out_length;
   } probe_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = OP_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE_INTERVAL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   trickle_dissemination_ctrl dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted controller state, advanced once per accepted transaction.
   logic [15:0]       cfg_base = 16'd128;
   logic [21:0]       cfg_max = 22'd4096;
   logic [7:0]        cfg_dup_limit = 8'd1;
   logic [7:0]        cur_version = 8'd0;
   logic [6:0]        cur_length = 7'd0;
   logic [4:0]        doublings = 5'd0;
   logic [7:0]        dups_heard = 8'd0;
   trickle_phase_type trk_phase = TRK_IDLE;
   logic [21:0]       listen_left = 22'd0;
   logic [21:0]       interval_left = 22'd0;
   logic [15:0]       first_send_left = 16'd0;
   logic              first_send_armed = 1'b0;

   tdc_entry_type  step_out [2];
   int             step_n;
   tdc_entry_type  due_announcements [$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  rx_cycles = 0;
   int  stall_left = 0;
   bit  calm_rx = 1'b0;
   bit  calm_tx = 1'b0;
   bit  quiet_tail = 1'b0;
   bit  hold_request = 1'b0;
   tdc_entry_type oldest_due;

   probe_row_type opening_rows [23] = '{
      '{OP_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'h80, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'd1, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 2'd1, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'h01, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'h7F, 16'd65,   16'h0000, 16'h0000, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'h7F, 16'd64,   16'hFFFF, 16'h0000, 1'b1, 2'd1, KIND_DELIVER,  8'h7F, 7'd64},
      '{OP_TICK,    8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'd1, KIND_TRANSMIT, 8'h7F, 7'd64},
      '{OP_HEADER,  8'h7F, 16'd3,    16'h0000, 16'h0000, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_PUBLISH, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 2'd1, KIND_TRANSMIT, 8'h80, 7'd64},
      '{OP_PUBLISH, 8'h00, 16'h0000, 16'h1234, 16'h0000, 1'b1, 2'd1, KIND_TRANSMIT, 8'h81, 7'd0},
      '{OP_NONE,    8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_HEADER,  8'h01, 16'h0000, 16'h0000, 16'h0000, 1'b1, 2'd1, KIND_TRANSMIT, 8'h81, 7'd0},
      '{OP_HEADER,  8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 2'd1, KIND_DELIVER,  8'h00, 7'd0},
      '{OP_HEADER,  8'h00, 16'd64,   16'h0000, 16'h0000, 1'b1, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'h5A5A, 16'hA5A5, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'h1357, 16'h2468, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'h8001, 16'h7FFE, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'h00FF, 16'hFF00, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_TICK,    8'h00, 16'h0000, 16'h4321, 16'h8765, 1'b0, 2'd0, KIND_TRANSMIT, 8'h00, 7'd0},
      '{OP_PUBLISH, 8'h55, 16'd64,   16'hFFFF, 16'h0000, 1'b1, 2'd1, KIND_TRANSMIT, 8'h01, 7'd64}
   };

   function automatic logic [63:0] raw_interval();
      return {48'd0, cfg_base} << doublings;
   endfunction

   function automatic void note_result(input logic kind);
      tdc_entry_type e;
      e.kind = kind;
      e.seqno = cur_version;
      e.length = cur_length;
      e.last = 1'b0;
      step_out[step_n] = e;
      step_n++;
   endfunction

   function automatic void start_trickle_interval(input logic [15:0] rnd);
      logic [63:0] iv;
      logic [31:0] half;
      iv = raw_interval();
      if (iv > {42'd0, cfg_max}) iv = {42'd0, cfg_max};
      half = iv[31:0] / 32'd2;
      listen_left = 22'(half + ((half != 0) ? {16'd0, rnd} % half : 32'd0));
      interval_left = iv[21:0];
      dups_heard = 8'd0;
      trk_phase = TRK_LISTEN;
   endfunction

   function automatic void advance_trickle(input logic [1:0] op, input logic [7:0] seq,
                                           input logic [15:0] len, input logic [15:0] rl,
                                           input logic [15:0] rf);
      logic [7:0] diff;
      logic       listen_fired;
      logic       interval_fired;
      step_n = 0;
      case (op)
         OP_TICK: begin
            // The first-send timer goes before the listen timer, so its result comes first.
            if (first_send_armed) begin
               if (first_send_left <= 16'd1) begin
                  first_send_left = 16'd0;
                  first_send_armed = 1'b0;
                  note_result(KIND_TRANSMIT);
               end else begin
                  first_send_left = first_send_left - 16'd1;
               end
            end
            if (trk_phase != TRK_IDLE) begin
               listen_fired = 1'b0;
               if (trk_phase == TRK_LISTEN) begin
                  if (listen_left <= 22'd1) begin
                     listen_left = 22'd0;
                     listen_fired = 1'b1;
                  end else begin
                     listen_left = listen_left - 22'd1;
                  end
               end
               interval_fired = (interval_left <= 22'd1);
               interval_left = interval_fired ? 22'd0 : interval_left - 22'd1;
               if (listen_fired) begin
                  if (dups_heard < cfg_dup_limit) note_result(KIND_TRANSMIT);
                  if (raw_interval() < {42'd0, cfg_max} && doublings != 5'd31)
                     doublings = doublings + 5'd1;
                  trk_phase = TRK_WAIT;
               end
               if (interval_fired && trk_phase == TRK_WAIT) start_trickle_interval(rl);
            end
         end
         OP_HEADER: begin
            diff = seq - cur_version;
            if (diff == 8'd0) begin
               if (dups_heard != 8'hFF) dups_heard = dups_heard + 8'd1;
            end else if (diff[7]) begin
               doublings = 5'd0;
               note_result(KIND_TRANSMIT);
            end else if (len <= 16'(MAX_PAYLOAD_DEF)) begin
               cur_version = seq;
               cur_length = len[6:0];
               doublings = 5'd0;
               start_trickle_interval(rl);
               first_send_left = (cfg_base != 16'd0) ? rf % cfg_base : 16'd0;
               first_send_armed = 1'b1;
               note_result(KIND_DELIVER);
            end
         end
         OP_PUBLISH: begin
            cur_length = (len > 16'(MAX_PAYLOAD_DEF)) ? 7'(MAX_PAYLOAD_DEF) : len[6:0];
            cur_version = cur_version + 8'd1;
            doublings = 5'd0;
            start_trickle_interval(rl);
            note_result(KIND_TRANSMIT);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [7:0] seq,
                            input logic [15:0] len, input logic [15:0] rl,
                            input logic [15:0] rf, input logic typed,
                            input logic [1:0] typed_n, input logic tkind,
                            input logic [7:0] tseq, input logic [6:0] tlen);
      tdc_entry_type e;
      int i;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {rf, rl, len, seq};
      do @(posedge clock); while (req_tready !== 1'b1);
      advance_trickle(op, seq, len, rl, rf);
      if (typed) begin
         if (typed_n != 2'd0) begin
            e.kind = tkind;
            e.seqno = tseq;
            e.length = tlen;
            e.last = 1'b1;
            due_announcements.push_back(e);
         end
      end else begin
         for (i = 0; i < step_n; i++) begin
            e = step_out[i];
            e.last = (i == step_n - 1);
            due_announcements.push_back(e);
         end
      end
      @(negedge clock);
   endtask

   task automatic maybe_pause();
      if (!quiet_tail && !calm_tx && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic random_item();
      logic [1:0]  op;
      logic [7:0]  seq;
      logic [15:0] len;
      int          pick;
      pick = $urandom_range(0, 99);
      op = (pick < 58) ? OP_TICK : (pick < 82) ? OP_HEADER : (pick < 95) ? OP_PUBLISH : OP_NONE;
      seq = 8'($urandom);
      len = 16'($urandom);
      if (op == OP_HEADER) begin
         // Mostly headers relative to the held version, so every comparison outcome is hit.
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            seq = cur_version;
         end else if (pick < 62) begin
            seq = cur_version + 8'($urandom_range(1, 127));
            len = 16'($urandom_range(0, MAX_PAYLOAD_DEF));
         end else if (pick < 70) begin
            seq = cur_version + 8'($urandom_range(1, 127));
         end else if (pick < 90) begin
            seq = cur_version + 8'($urandom_range(128, 255));
         end
      end else if (op == OP_PUBLISH && $urandom_range(0, 3) != 0) begin
         len = 16'($urandom_range(0, MAX_PAYLOAD_DEF));
      end
      send_item(op, seq, len, 16'($urandom), 16'($urandom), 1'b0, 2'd0, KIND_TRANSMIT,
                8'd0, 7'd0);
      maybe_pause();
   endtask

   // Waits until every predicted result has arrived and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_announcements.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_BASE_INTERVAL: cfg_base = value[15:0];
         CSR_MAX_INTERVAL:  cfg_max = value;
         CSR_DUP_THRESHOLD: cfg_dup_limit = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [21:0] base, input logic [21:0] max_iv,
                            input logic [21:0] dup_limit);
      settle();
      write_reg(CSR_BASE_INTERVAL, base);
      write_reg(CSR_MAX_INTERVAL, max_iv);
      write_reg(CSR_DUP_THRESHOLD, dup_limit);
   endtask

   task automatic run_phase(input logic [21:0] base, input logic [21:0] max_iv,
                            input logic [21:0] dup_limit, input int count);
      int i;
      configure(base, max_iv, dup_limit);
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
         random_item();
      end
   endtask

   initial begin
      int i;
      probe_row_type r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening_rows[k]) begin
         r = opening_rows[k];
         send_item(r.op, r.seqno, r.length, r.rnd_listen, r.rnd_first, r.typed, r.typed_n,
                   r.kind, r.out_seqno, r.out_length);
         maybe_pause();
      end

      // Flood of duplicates: the counter must saturate, so the listen send of that interval is suppressed.
      configure(22'd4, 22'd16, 22'd255);
      send_item(OP_PUBLISH, 8'd0, 16'd17, 16'($urandom), 16'($urandom), 1'b0, 2'd0,
                KIND_TRANSMIT, 8'd0, 7'd0);
      for (i = 0; i < 300; i++)
         send_item(OP_HEADER, cur_version, 16'($urandom), 16'($urandom), 16'($urandom),
                   1'b0, 2'd0, KIND_TRANSMIT, 8'd0, 7'd0);
      for (i = 0; i < 20; i++)
         send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'b0, 2'd0, KIND_TRANSMIT, 8'd0, 7'd0);

      // Back-to-back publishes against a receiver that holds off, to back up the result queue until req_tready drops.
      hold_request = 1'b1;
      for (i = 0; i < 24; i++)
         send_item(OP_PUBLISH, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'b0, 2'd0, KIND_TRANSMIT, 8'd0, 7'd0);

      run_phase(22'd1, 22'd1, 22'd255, 250);
      run_phase(22'd3, 22'd40, 22'd1, 400);
      run_phase(22'd60, 22'd50, 22'd2, 400);
      run_phase(22'd65535, 22'd4194303, 22'd0, 40);
      run_phase(22'd1, 22'd4194303, 22'd1, 250);
      quiet_tail = 1'b1;
      run_phase(22'd2, 22'd9, 22'd3, 250);
      settle();

      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rx_cycles++;
         if (rx_cycles % 128 == 0) calm_rx = ($urandom_range(0, 2) == 0);
         if (quiet_tail) begin
            rsp_tready <= 1'b1;
         end else if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm_rx && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
         end
      end
   end

   // Reported fields are in the order kind, seqno, length, last.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_announcements.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected none, got %0d %0d %0d %0d",
                     $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[14:8], rsp_tlast);
         end else begin
            oldest_due = due_announcements.pop_front();
            if (rsp_tuser !== oldest_due.kind || rsp_tdata[7:0] !== oldest_due.seqno ||
                rsp_tdata[14:8] !== oldest_due.length || rsp_tdata[15] !== 1'b0 ||
                rsp_tlast !== oldest_due.last) begin
               mismatch_count++;
               $display("%0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d pad %0d",
                        $time, oldest_due.kind, oldest_due.seqno, oldest_due.length,
                        oldest_due.last, rsp_tuser, rsp_tdata[7:0], rsp_tdata[14:8],
                        rsp_tlast, rsp_tdata[15]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

endmodule
